// ===== rtl/rmf_pkg.sv =====
// rmf_pkg: shared types and constants for the running median filter
// holds the sorted cell entry type and request codes; no dependencies

package rmf_pkg;

  // default window depth, the age field width (enough for windows up to 32 deep) and sample width
  localparam int unsigned WINDOW_DEPTH_DEF = 5;
  localparam int unsigned AGE_W            = 5;
  localparam int unsigned SAMPLE_W         = 16;

  // request kinds carried on the input tuser
  typedef enum logic {
    REQ_PUSH  = 1'b0,
    REQ_CLEAR = 1'b1
  } req_e;

  // one entry of the sorted chain
  typedef struct packed {
    logic                vld;
    logic [AGE_W-1:0]    age;
    logic [SAMPLE_W-1:0] val;
  } cell_t;

endpackage

// ===== rtl/rmf_cell.sv =====
// rmf_cell: one slot of the sorted sample chain
// holds a sample with its age; on a push it takes the new sample, keeps its entry or takes a neighbor's; uses rmf_pkg

module rmf_cell
  import rmf_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                clear_i,
  input  logic                full_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  cell_t               left_i,
  input  logic                left_gt_i,
  input  cell_t               right_i,
  input  logic                right_gt_i,
  input  logic                rm_i,
  output cell_t               cell_o,
  output logic                gt_o,
  output logic                rm_o
);

  cell_t cell_q, cell_d;
  logic  ev;
  cell_t cand_a, cand_b, pick;
  logic  gt_a, gt_b, take_new;

  // new sample sorts ahead of this entry (empty slots count as larger)
  assign gt_o = !cell_q.vld || (cell_q.val > sample_i);

  // this entry is the oldest one and leaves on a push into a full window
  assign ev   = push_i && full_i && cell_q.vld &&
                (cell_q.age == AGE_W'(WINDOW_DEPTH - 1));
  assign rm_o = rm_i || ev;

  // pick the post-eviction neighbors, then the insertion choice
  always_comb begin
    if (rm_i) begin
      cand_a = right_i;
      gt_a   = right_gt_i;
      cand_b = cell_q;
      gt_b   = gt_o;
    end else if (ev) begin
      cand_a = right_i;
      gt_a   = right_gt_i;
      cand_b = left_i;
      gt_b   = left_gt_i;
    end else begin
      cand_a = cell_q;
      gt_a   = gt_o;
      cand_b = left_i;
      gt_b   = left_gt_i;
    end
    take_new = gt_a && !gt_b;
    pick     = gt_a ? cand_b : cand_a;
    cell_d   = cell_q;
    if (clear_i) begin
      cell_d.vld = 1'b0;
    end else if (push_i) begin
      if (take_new) begin
        cell_d.vld = 1'b1;
        cell_d.age = '0;
        cell_d.val = sample_i;
      end else begin
        cell_d.vld = pick.vld;
        cell_d.age = pick.age + AGE_W'(1);
        cell_d.val = pick.val;
      end
    end
  end

  // entry register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ===== rtl/running_median_filter.sv =====
// running_median_filter: median of the last WINDOW_DEPTH samples via a sorted cell chain
// a push passes the chain update, then the median select into the output register; a held output stalls it
// throughput: one item per cycle while the output is taken; the chain inserts and evicts in the same cycle
// a clear transfer empties the chain and gives no result
// reset: asynchronous, active low; empties the window and drops any pending result
// depends on rmf_pkg and rmf_cell

module running_median_filter
  import rmf_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [15:0]         s_axis_tdata_i,  // [15:0] distance_mm
  input  logic                s_axis_tuser_i,  // [0] req_type
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [15:0]         m_axis_tdata_o   // [15:0] median_mm
);

  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  logic          in_xfer, push, clear, full, pend_move;
  logic          pend_q, pend_d, out_vld_q, out_vld_d;
  logic [CW-1:0] cnt_q, cnt_d, mid;
  logic [15:0]   out_q;
  cell_t         cells [WINDOW_DEPTH];
  logic          gts   [WINDOW_DEPTH];
  logic          rms   [WINDOW_DEPTH+1];
  cell_t         empty_cell;

  // input transfer decode
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;
  assign push    = in_xfer && (req_e'(s_axis_tuser_i) == REQ_PUSH);
  assign clear   = in_xfer && (req_e'(s_axis_tuser_i) == REQ_CLEAR);
  assign full    = (cnt_q == CW'(WINDOW_DEPTH));

  assign empty_cell = '0;
  assign rms[0]     = 1'b0;

  // sorted chain of cells
  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    cell_t left_c, right_c;
    logic  left_gt, right_gt;
    if (i == 0) begin : g_lo
      assign left_c  = empty_cell;
      assign left_gt = 1'b0;
    end else begin : g_lo
      assign left_c  = cells[i-1];
      assign left_gt = gts[i-1];
    end
    if (i == WINDOW_DEPTH - 1) begin : g_hi
      assign right_c  = empty_cell;
      assign right_gt = 1'b1;
    end else begin : g_hi
      assign right_c  = cells[i+1];
      assign right_gt = gts[i+1];
    end
    rmf_cell #(
      .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .push_i    (push),
      .clear_i   (clear),
      .full_i    (full),
      .sample_i  (s_axis_tdata_i),
      .left_i    (left_c),
      .left_gt_i (left_gt),
      .right_i   (right_c),
      .right_gt_i(right_gt),
      .rm_i      (rms[i]),
      .cell_o    (cells[i]),
      .gt_o      (gts[i]),
      .rm_o      (rms[i+1])
    );
  end

  // fill count and pending result control
  assign pend_move       = pend_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !pend_q || pend_move;

  always_comb begin
    cnt_d = cnt_q;
    if (clear) begin
      cnt_d = '0;
    end else if (push && !full) begin
      cnt_d = cnt_q + CW'(1);
    end
    pend_d = push || (pend_q && !pend_move);
    out_vld_d = pend_move || (out_vld_q && !m_axis_tready_i);
  end

  // median slot at index count/2
  assign mid = cnt_q >> 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (pend_move) begin
      out_q <= cells[mid[IW-1:0]].val;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

endmodule
